/* hw/rtl/combined_lcg_shuffle_uniform_defines.svh */
// Assertion macros used by the uniform generator checker.
`ifndef COMBINED_LCG_SHUFFLE_UNIFORM_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_UNIFORM_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CLSU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CLSU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/clsu_pkg.sv */
// Types and constants of the combined generator with shuffle table.
package clsu_pkg;

   localparam int VAL_W  = 31;
   localparam int SEED_W = 32;
   localparam int MUL_W  = 16;
   localparam int FOLD_W = 8;

   localparam logic [VAL_W-1:0] MOD1       = 31'd2147483563;
   localparam logic [VAL_W-1:0] MOD2       = 31'd2147483399;
   localparam logic [VAL_W-1:0] MOD1M1     = 31'd2147483562;
   localparam logic [VAL_W-1:0] CEIL_LIMIT = 31'd2147483305;

   localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
   localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

   // 2^31 mod each modulus
   localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
   localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;

   localparam int RECIP_SHIFT = 40;
   localparam int WARMUP      = 8;

   localparam logic signed [SEED_W-1:0] SEED_RESET = -32'sd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_FOLD,
      ST_DRAW_MUL,
      ST_DRAW_FOLD,
      ST_DRAW_OUT,
      ST_INDEX
   } state_type;

   typedef enum logic {
      GEN_FIRST,
      GEN_SECOND
   } gen_sel_type;

endpackage

/* hw/rtl/clsu_mulmod.sv */
// Multiply-modulo step of one multiplicative generator, with the product registered before the fold.
module clsu_mulmod (
   input  logic                        clock,
   input  clsu_pkg::gen_sel_type       gen_sel,
   input  logic [clsu_pkg::VAL_W-1:0]  x,
   output logic [clsu_pkg::VAL_W-1:0]  result
);
   import clsu_pkg::*;

   localparam int PROD_W = VAL_W + MUL_W;
   localparam int HI_W   = PROD_W - VAL_W;
   localparam int SCL_W  = HI_W + FOLD_W;

   logic [MUL_W-1:0]  mul;
   logic [PROD_W-1:0] prod_in, prod_ff;
   gen_sel_type       sel_in, sel_ff;
   logic [FOLD_W-1:0] fold;
   logic [VAL_W-1:0]  modulus;
   logic [SCL_W-1:0]  hi_scaled;
   logic [VAL_W:0]    sum, diff;

   always_comb begin
      mul     = (gen_sel == GEN_SECOND) ? MUL2 : MUL1;
      prod_in = PROD_W'(x) * PROD_W'(mul);
      sel_in  = gen_sel;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sel_ff  <= sel_in;
   end

   // fold the bits above 2^31 back in, then one conditional subtract
   always_comb begin
      fold      = (sel_ff == GEN_SECOND) ? FOLD2 : FOLD1;
      modulus   = (sel_ff == GEN_SECOND) ? MOD2 : MOD1;
      hi_scaled = SCL_W'(prod_ff[PROD_W-1:VAL_W]) * SCL_W'(fold);
      sum       = (VAL_W+1)'(prod_ff[VAL_W-1:0]) + (VAL_W+1)'(hi_scaled);
      diff      = sum - (VAL_W+1)'(modulus);
      result    = (sum >= (VAL_W+1)'(modulus)) ? diff[VAL_W-1:0] : sum[VAL_W-1:0];
   end

endmodule

/* hw/rtl/clsu_bucket.sv */
// Shuffle index unit: previous output divided by the bucket size, with the estimate registered on load.
module clsu_bucket #(
   parameter  int TABLE_DEPTH = 32,
   localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                       clock,
   input  logic                       load,
   input  logic [clsu_pkg::VAL_W-1:0] value,
   output logic [IDX_W-1:0]           idx
);
   import clsu_pkg::*;

   localparam int    EST_W  = IDX_W + 1;
   localparam longint BUCKET = 64'(MOD1M1) / TABLE_DEPTH + 1;
   localparam longint RECIP  = (64'd1 << RECIP_SHIFT) / BUCKET;
   localparam int    PROD_W = RECIP_SHIFT + EST_W;
   localparam int    CHK_W  = VAL_W + EST_W;

   logic [PROD_W-1:0] prod;
   logic [EST_W-1:0]  est_in, est_ff, est_next, fixed;
   logic [VAL_W-1:0]  value_ff;
   logic [CHK_W-1:0]  upper;

   // reciprocal estimate is exact or one low
   always_comb begin
      prod   = PROD_W'(value) * PROD_W'(RECIP);
      est_in = prod[RECIP_SHIFT +: EST_W];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value;
         est_ff   <= est_in;
      end
   end

   always_comb begin
      est_next = est_ff + EST_W'(1);
      upper    = CHK_W'(est_next) * CHK_W'(BUCKET);
      fixed    = (CHK_W'(value_ff) >= upper) ? est_next : est_ff;
      if (fixed >= EST_W'(TABLE_DEPTH)) begin
         fixed = EST_W'(TABLE_DEPTH - 1);
      end
      idx = fixed[IDX_W-1:0];
   end

endmodule

/* hw/rtl/clsu_table.sv */
// Shuffle table memory: one port, read-first, registered read data.
module clsu_table #(
   parameter  int TABLE_DEPTH = 32,
   localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                       clock,
   input  logic                       write_enable,
   input  logic [IDX_W-1:0]           addr,
   input  logic [clsu_pkg::VAL_W-1:0] write_data,
   output logic [clsu_pkg::VAL_W-1:0] read_data
);
   import clsu_pkg::*;

   logic [VAL_W-1:0] mem [TABLE_DEPTH];
   logic [VAL_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[addr] <= write_data;
      end
      read_data_ff <= mem[addr];
   end

   assign read_data = read_data_ff;

endmodule

/* hw/rtl/combined_lcg_shuffle_uniform.sv */
// Top level of the combined multiplicative uniform generator with shuffle table.
// Each draw transaction returns a 31-bit numerator in 1..2147483562 (the uniform
// value is numerator / 2147483563) and a flag that is set when the value lies
// above 1 - 1.2e-7. Two multiplicative generators (mod 2147483563 and mod
// 2147483399) run through registered multiply-modulo units; their difference is
// mixed through a TABLE_DEPTH-entry shuffle table held in a single-port memory.
// A seeded draw runs from acceptance through multiply, fold with table
// read-modify-write, output, and the index divide that picks the next table
// entry, then returns to idle for the next acceptance. The first draw after
// reset or after a seed write first runs the seeding: TABLE_DEPTH + 8 warm-up
// steps through the first generator's unit, filling the table, plus an index
// step, after which the draw itself proceeds. A transaction with the request
// bit clear is accepted while idle and returns nothing. The result sits in an
// output register, so a finished result may wait for the consumer while the
// next request is accepted; that draw then holds in its fold stage, before the
// table update, until the output register is free. Write the seed only while no
// draw is in flight; the magnitude of the seed is used, zero acts as one.
module combined_lcg_shuffle_uniform #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_draw_request,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [clsu_pkg::VAL_W-1:0]        rsp_uniform_numerator,
   output logic                              rsp_at_ceiling,
   input  logic                              csr_wr_en,
   input  logic signed [clsu_pkg::SEED_W-1:0] csr_wr_data
);
   import clsu_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + WARMUP);

   state_type                state_ff, state_in;
   logic signed [SEED_W-1:0] seed_ff, seed_in;
   logic                     seeded_ff, seeded_in;
   logic                     pend_ff, pend_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [VAL_W-1:0]         gen1_ff, gen1_in;
   logic [VAL_W-1:0]         gen2_ff, gen2_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]         numer_ff, numer_in;
   logic                     ceil_ff, ceil_in;

   logic [VAL_W-1:0]  gen1_step, gen2_step;
   logic [VAL_W-1:0]  rd_data;
   logic              tbl_we;
   logic [IDX_W-1:0]  tbl_addr;
   logic [VAL_W-1:0]  tbl_wdata;
   logic              bucket_load;
   logic [VAL_W-1:0]  bucket_value;
   logic [IDX_W-1:0]  bucket_idx;
   logic [SEED_W-1:0] seed_neg, seed_abs;
   logic [VAL_W-1:0]  seed_mag;
   logic [VAL_W:0]    draw_sum;
   logic [VAL_W-1:0]  draw_val;

   clsu_mulmod u_mulmod_first (
      .clock   (clock),
      .gen_sel (GEN_FIRST),
      .x       (gen1_ff),
      .result  (gen1_step)
   );

   clsu_mulmod u_mulmod_second (
      .clock   (clock),
      .gen_sel (GEN_SECOND),
      .x       (gen2_ff),
      .result  (gen2_step)
   );

   clsu_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock        (clock),
      .write_enable (tbl_we),
      .addr         (tbl_addr),
      .write_data   (tbl_wdata),
      .read_data    (rd_data)
   );

   clsu_bucket #(.TABLE_DEPTH(TABLE_DEPTH)) u_bucket (
      .clock (clock),
      .load  (bucket_load),
      .value (bucket_value),
      .idx   (bucket_idx)
   );

   // seed magnitude; most negative saturates, zero becomes one
   always_comb begin
      seed_neg = -seed_ff;
      seed_abs = seed_ff[SEED_W-1] ? seed_neg : seed_ff;
      if (seed_abs[SEED_W-1]) begin
         seed_mag = '1;
      end else begin
         seed_mag = seed_abs[VAL_W-1:0];
      end
      if (seed_mag == '0) begin
         seed_mag = VAL_W'(1);
      end
   end

   // wrap a non-positive difference back into 1..MOD1M1
   always_comb begin
      if (rd_data > gen2_ff) begin
         draw_sum = (VAL_W+1)'(rd_data) - (VAL_W+1)'(gen2_ff);
      end else begin
         draw_sum = (VAL_W+1)'(rd_data) + (VAL_W+1)'(MOD1M1) - (VAL_W+1)'(gen2_ff);
      end
      draw_val = draw_sum[VAL_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      gen1_in      = gen1_ff;
      gen2_in      = gen2_ff;
      idx_in       = idx_ff;
      tbl_we       = 1'b0;
      tbl_addr     = idx_ff;
      tbl_wdata    = gen1_step;
      bucket_load  = 1'b0;
      bucket_value = draw_val;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      numer_in     = numer_ff;
      ceil_in      = ceil_ff;
      req_stall    = (state_ff != ST_IDLE);
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_draw_request) begin
               if (!seeded_ff) begin
                  gen1_in  = seed_mag;
                  gen2_in  = seed_mag;
                  cnt_in   = CNT_W'(TABLE_DEPTH + WARMUP - 1);
                  state_in = ST_SEED_MUL;
               end else begin
                  state_in = ST_DRAW_MUL;
               end
            end
         end
         ST_SEED_MUL: begin
            state_in = ST_SEED_FOLD;
         end
         ST_SEED_FOLD: begin
            // warm-up steps above the table depth are dropped
            gen1_in  = gen1_step;
            tbl_addr = cnt_ff[IDX_W-1:0];
            tbl_we   = (cnt_ff < CNT_W'(TABLE_DEPTH));
            if (cnt_ff == '0) begin
               bucket_load  = 1'b1;
               bucket_value = gen1_step;
               seeded_in    = 1'b1;
               pend_in      = 1'b1;
               state_in     = ST_INDEX;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_SEED_MUL;
            end
         end
         ST_DRAW_MUL: begin
            state_in = ST_DRAW_FOLD;
         end
         ST_DRAW_FOLD: begin
            // hold the table entry unwritten until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               gen1_in  = gen1_step;
               gen2_in  = gen2_step;
               tbl_we   = 1'b1;
               state_in = ST_DRAW_OUT;
            end
         end
         ST_DRAW_OUT: begin
            rsp_valid_in = 1'b1;
            numer_in     = draw_val;
            ceil_in      = (draw_val > CEIL_LIMIT);
            bucket_load  = 1'b1;
            state_in     = ST_INDEX;
         end
         ST_INDEX: begin
            idx_in   = bucket_idx;
            pend_in  = 1'b0;
            state_in = pend_ff ? ST_DRAW_MUL : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         seeded_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         seeded_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         seeded_ff    <= seeded_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      gen1_ff  <= gen1_in;
      gen2_ff  <= gen2_in;
      idx_ff   <= idx_in;
      numer_ff <= numer_in;
      ceil_ff  <= ceil_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_uniform_numerator = numer_ff;
   assign rsp_at_ceiling        = ceil_ff;

endmodule

/* hw/rtl/clsu_checker.sv */
// Port-level checker for the uniform generator, bound to the top level.
`include "combined_lcg_shuffle_uniform_defines.svh"

module clsu_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_draw_request,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [clsu_pkg::VAL_W-1:0] rsp_uniform_numerator,
   input logic                       rsp_at_ceiling
);
   import clsu_pkg::*;

   `CLSU_ASSERT_SAME(a_numer_range, rsp_valid, (rsp_uniform_numerator != '0) && (rsp_uniform_numerator <= MOD1M1), "numerator out of range")

   `CLSU_ASSERT_SAME(a_ceiling_flag, rsp_valid, rsp_at_ceiling == (rsp_uniform_numerator > CEIL_LIMIT), "ceiling flag disagrees with numerator")

   `CLSU_ASSERT_NEXT(a_hold_stalled, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_uniform_numerator) && $stable(rsp_at_ceiling), "stalled result changed")

   `CLSU_ASSERT_NEXT(a_busy_after_draw, req_valid && !req_stall && req_draw_request, req_stall, "draw transaction did not occupy the block")

endmodule

bind combined_lcg_shuffle_uniform clsu_checker u_clsu_checker (.*);
